// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned ENTRY_W  = DATA_W + PRIO_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_TAKE,
    ST_RESP
  } state_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data;
    logic signed [PRIO_W-1:0]  prio;
    logic        [OCC_W-1:0]   occupancy;
  } result_t;

endpackage

// ===== src/spq_in_if.sv =====
`timescale 1ns / 1ps

interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] in_data;
  logic signed [PRIO_W-1:0] in_priority;

  modport source (output valid, cmd, in_data, in_priority, input ready);
  modport sink   (input valid, cmd, in_data, in_priority, output ready);

endinterface

// ===== src/spq_out_if.sv =====
`timescale 1ns / 1ps

interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] out_data;
  logic signed [PRIO_W-1:0] out_priority;
  logic        [OCC_W-1:0]  occupancy;

  modport source (output valid, status, out_data, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_data, out_priority, occupancy, output ready);

endinterface

// ===== src/spq_ram.sv =====
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spq_seq.sv =====
`timescale 1ns / 1ps

module spq_seq (
  input  logic                        clk,
  input  logic                        rst,
  spq_in_if.sink                      req,
  input  logic                        out_free,
  output logic                        res_valid,
  output spq_pkg::result_t            res,
  output logic                        ram_we,
  output logic [spq_pkg::IDX_W-1:0]   ram_waddr,
  output logic [spq_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [spq_pkg::IDX_W-1:0]   ram_raddr,
  input  logic [spq_pkg::ENTRY_W-1:0] ram_rdata
);
  import spq_pkg::*;

  // Entries live in a circular buffer; logical slot zero is the head.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [IDX_W-1:0] k);
    logic [IDX_W:0] s;
    s = {1'b0, h} + {1'b0, k};
    if (s >= (IDX_W + 1)'(CAPACITY)) begin
      s = s - (IDX_W + 1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t                   state, state_next;
  logic [IDX_W-1:0]         head, head_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         k, k_next;
  result_t                  res_next;
  logic signed [DATA_W-1:0] new_data;
  logic signed [PRIO_W-1:0] new_prio;
  logic signed [PRIO_W-1:0] rd_prio;
  logic                     accept;

  assign rd_prio = ram_rdata[ENTRY_W-1 -: PRIO_W];
  assign accept  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    k   <= k_next;
    res <= res_next;
    if (accept) begin
      new_data <= req.in_data;
      new_prio <= req.in_priority;
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    k_next     = k;
    res_next   = res;
    req.ready  = (state == ST_IDLE);
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = phys(head, k);
    ram_wdata  = {new_prio, new_data};
    ram_raddr  = phys(head, k - 1'b1);
    case (state)
      ST_IDLE: begin
        ram_raddr = head;
        if (req.valid) begin
          res_next = '{STATUS_OK, '0, '0, OCC_W'(count)};
          if (req.cmd == CMD_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_next.status = STATUS_FULL;
              state_next      = ST_RESP;
            end else begin
              k_next     = count[IDX_W-1:0];
              state_next = ST_INS_RD;
            end
          end else begin
            if (count == '0) begin
              res_next.status = STATUS_EMPTY;
              state_next      = ST_RESP;
            end else begin
              state_next = ST_REM_TAKE;
            end
          end
        end
      end
      ST_INS_RD: begin
        if (k == '0) begin
          ram_we             = 1'b1;
          count_next         = count + 1'b1;
          res_next.occupancy = OCC_W'(count + 1'b1);
          state_next         = ST_RESP;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_prio > new_prio) begin
          ram_wdata  = ram_rdata;
          k_next     = k - 1'b1;
          state_next = ST_INS_RD;
        end else begin
          count_next         = count + 1'b1;
          res_next.occupancy = OCC_W'(count + 1'b1);
          state_next         = ST_RESP;
        end
      end
      ST_REM_TAKE: begin
        res_next.data      = ram_rdata[DATA_W-1:0];
        res_next.prio      = rd_prio;
        res_next.occupancy = OCC_W'(count - 1'b1);
        count_next         = count - 1'b1;
        head_next          = phys(head, IDX_W'(1));
        state_next         = ST_RESP;
      end
      ST_RESP: begin
        res_valid = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Bounded priority queue of CAPACITY entries, kept sorted by signed priority.
// The req channel carries one command per transaction: an insert with a data
// word and a priority, or a removal of the head entry. The rsp channel returns
// one transaction per command with a status, the removed entry (zero when
// none) and the occupancy after the command. Smaller priorities leave first,
// and equal priorities leave in arrival order.
// The queue is a circular buffer in a single-port-read RAM. A removal reads the
// head entry and registers it as the result. An insert walks back from the
// tail through one shared comparator, reading each entry and moving it up one
// slot while its priority is larger, then writes the new entry into the gap.
// An insert when full or a removal when empty returns a FULL or EMPTY status.
// One command is in progress at a time; req.ready is high only while idle.
// The result waits in an output register; if rsp is stalled, the block holds
// the next result and takes no new command until the register is free.
// A synchronous reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue (
  input  logic       clk,
  input  logic       rst,
  spq_in_if.sink     req,
  spq_out_if.source  rsp
);
  import spq_pkg::*;

  logic                 out_free;
  logic                 res_valid;
  result_t              res;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  assign out_free = !rsp.valid || rsp.ready;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (res_valid) begin
      rsp.status       <= res.status;
      rsp.out_data     <= res.data;
      rsp.out_priority <= res.prio;
      rsp.occupancy    <= res.occupancy;
    end
  end

endmodule
